[sv/mlru_pkg.sv]
// Package for the matrix LRU replacement block.
// Holds the opcode constants, controller state type and control structs.
// Depends on nothing; used by every module of the block.
package mlru_pkg;

    localparam int OP_W = 3;
    localparam int FRAME_W = 3;

    localparam logic [OP_W-1:0] OP_REFERENCE = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
    localparam logic [OP_W-1:0] OP_SWAP      = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic apply_op;
        logic scan_start;
        logic scan_step;
        logic load_direct;
        logic load_scan;
    } t_cmd;

    typedef struct packed {
        logic is_find;
        logic scan_last;
    } t_status;

endpackage

[sv/mlru_ctrl.sv]
// Controller state machine for the matrix LRU replacement block.
// Sequences operation updates, the row-by-row victim scan and the output word.
// Depends on mlru_pkg.
module mlru_ctrl
    import mlru_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign accept      = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.apply_op = 1'b1;
                    if (i_status.is_find) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.load_direct = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last && out_free) begin
                    o_cmd.load_scan = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.load_direct || o_cmd.load_scan) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

[sv/mlru_dp.sv]
// Datapath for the matrix LRU replacement block: the LRU bit matrix,
// occupied marks, the victim scan registers and the output word register.
// Depends on mlru_pkg.
module mlru_dp
    import mlru_pkg::*;
#(
    parameter int FRAMES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [FRAME_W-1:0] i_frame_a,
    input  logic [FRAME_W-1:0] i_frame_b,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    output logic [FRAME_W-1:0] o_victim_frame,
    output logic               o_victim_found
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = ((IW > FRAME_W) ? IW : FRAME_W) + 1;

    logic [FRAMES-1:0] r_mat [FRAMES];
    logic [FRAMES-1:0] n_mat [FRAMES];
    logic [FRAMES-1:0] perm  [FRAMES];
    logic [FRAMES-1:0] r_occ, n_occ;

    logic [IW-1:0]     r_idx;
    logic [FRAMES-1:0] r_best, n_best;
    logic [IW-1:0]     r_victim, n_victim;
    logic              r_found, n_found;

    logic [FRAME_W-1:0] r_out_frame;
    logic               r_out_found;

    logic              a_ok, b_ok;
    logic [IW-1:0]     ia, ib, pa, pb;
    logic [FRAMES-1:0] col_a;
    logic [FRAMES-1:0] cur_row;
    logic              take;

    assign a_ok = CW'(i_frame_a) < CW'(FRAMES);
    assign b_ok = CW'(i_frame_b) < CW'(FRAMES);
    assign ia   = IW'(i_frame_a);
    assign ib   = IW'(i_frame_b);
    assign pa   = IW'(FRAMES - 1) - ia;
    assign pb   = IW'(FRAMES - 1) - ib;

    assign o_status.is_find   = (i_opcode == OP_FIND);
    assign o_status.scan_last = (r_idx == IW'(FRAMES - 1));

    always_comb begin
        col_a     = '0;
        col_a[pa] = 1'b1;
    end

    always_comb begin
        n_occ = r_occ;
        for (int r = 0; r < FRAMES; r++) begin
            n_mat[r] = r_mat[r];
            if (IW'(r) == ia) begin
                perm[r] = r_mat[ib];
            end else if (IW'(r) == ib) begin
                perm[r] = r_mat[ia];
            end else begin
                perm[r] = r_mat[r];
            end
        end
        if (i_cmd.apply_op) begin
            case (i_opcode)
                OP_REFERENCE: begin
                    if (a_ok) begin
                        for (int r = 0; r < FRAMES; r++) begin
                            if (IW'(r) == ia) begin
                                n_mat[r] = ~col_a;
                            end else begin
                                n_mat[r] = r_mat[r] & ~col_a;
                            end
                        end
                        n_occ[ia] = 1'b1;
                    end
                end
                OP_FREE: begin
                    if (a_ok) begin
                        n_mat[ia] = '0;
                        n_occ[ia] = 1'b0;
                    end
                end
                OP_SWAP: begin
                    if (a_ok && b_ok && (ia != ib)) begin
                        for (int r = 0; r < FRAMES; r++) begin
                            for (int k = 0; k < FRAMES; k++) begin
                                if (IW'(k) == pa) begin
                                    n_mat[r][k] = perm[r][pb];
                                end else if (IW'(k) == pb) begin
                                    n_mat[r][k] = perm[r][pa];
                                end else begin
                                    n_mat[r][k] = perm[r][k];
                                end
                            end
                        end
                        n_occ[ia] = r_occ[ib];
                        n_occ[ib] = r_occ[ia];
                    end
                end
                OP_CLEAR: begin
                    for (int r = 0; r < FRAMES; r++) begin
                        n_mat[r] = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign cur_row = r_mat[r_idx];
    assign take    = r_occ[r_idx] && (!r_found || (cur_row < r_best));

    always_comb begin
        n_best   = r_best;
        n_victim = r_victim;
        n_found  = r_found;
        if (i_cmd.scan_step && take) begin
            n_best   = cur_row;
            n_victim = r_idx;
            n_found  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < FRAMES; r++) begin
                r_mat[r] <= '0;
            end
            r_occ   <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
        end else begin
            r_mat <= n_mat;
            r_occ <= n_occ;
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else begin
                r_found <= n_found;
                if (i_cmd.scan_step && !o_status.scan_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best   <= n_best;
        r_victim <= n_victim;
        if (i_cmd.load_direct) begin
            r_out_frame <= '0;
            r_out_found <= 1'b0;
        end else if (i_cmd.load_scan) begin
            r_out_frame <= n_found ? FRAME_W'(n_victim) : '0;
            r_out_found <= n_found;
        end
    end

    assign o_victim_frame = r_out_frame;
    assign o_victim_found = r_out_found;

endmodule

[sv/matrix_lru_replacement.sv]
// Top level of the matrix LRU replacement block over FRAMES page frames.
// Joins the controller (mlru_ctrl) and the datapath (mlru_dp); uses mlru_pkg.
//
//  Channel  Handshake                 Word contents
//  input    i_in_valid / o_in_stall   i_opcode, i_frame_a, i_frame_b
//  output   o_out_valid / i_out_stall o_victim_frame, o_victim_found
//
// Reference, free, swap, clear and unused opcodes place their word in the
// output register at the accepting edge.
// Find victim scans one matrix row per cycle, holding on the last row while the
// output register is full and stalled, and loads its word at the last row.
// A new word is taken only when no scan runs and the output register is empty
// or being drained. Reset is synchronous and clears the matrix and marks.
module matrix_lru_replacement
    import mlru_pkg::*;
#(
    parameter int FRAMES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_opcode,
    input  logic [FRAME_W-1:0] i_frame_a,
    input  logic [FRAME_W-1:0] i_frame_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [FRAME_W-1:0] o_victim_frame,
    output logic               o_victim_found
);

    t_cmd    cmd;
    t_status status;

    mlru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mlru_dp #(
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_opcode),
        .i_frame_a      (i_frame_a),
        .i_frame_b      (i_frame_b),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_victim_frame (o_victim_frame),
        .o_victim_found (o_victim_found)
    );

endmodule

[dv/tb_top.sv]
// Testbench for matrix_lru_replacement: a directed table followed by random words,
// each result checked against the typed table word or a matrix LRU predictor.
// Depends on mlru_pkg and the RTL of the block.
module tb_top;
    import mlru_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N            = 8;
    localparam int PLAN_LEN     = 24;
    localparam int RANDOM_WORDS = 1750;
    localparam int PAUSE_AT     = PLAN_LEN + 900;

    localparam logic [OP_W-1:0] OP_SPARE0 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE1 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE2 = 3'd7;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               found;
    } t_victim_word;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [FRAME_W-1:0] fa;
        logic [FRAME_W-1:0] fb;
        logic               typed;
        t_victim_word       want;
    } t_lru_cmd;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_opcode;
    logic [FRAME_W-1:0] i_frame_a;
    logic [FRAME_W-1:0] i_frame_b;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [FRAME_W-1:0] o_victim_frame;
    logic               o_victim_found;

    logic [N-1:0] lru_rows [N];
    logic [N-1:0] occ_marks;
    t_victim_word victim_q [$];
    int           mismatches = 0;
    bit           calm = 1'b0;

    t_lru_cmd plan [PLAN_LEN] = '{
        '{OP_FIND,   3'd0, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_CLEAR,  3'd0, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_REFERENCE, 3'd0, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_REFERENCE, 3'd7, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_REFERENCE, 3'd3, 3'd5, 1'b1, '{3'd0, 1'b0}},
        '{OP_FIND,   3'd0, 3'd0, 1'b0, '{3'd0, 1'b0}},
        '{OP_SWAP,   3'd0, 3'd7, 1'b1, '{3'd0, 1'b0}},
        '{OP_SWAP,   3'd3, 3'd3, 1'b1, '{3'd0, 1'b0}},
        '{OP_FIND,   3'd0, 3'd0, 1'b0, '{3'd0, 1'b0}},
        '{OP_FREE,   3'd7, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_FIND,   3'd0, 3'd0, 1'b0, '{3'd0, 1'b0}},
        '{OP_REFERENCE, 3'd7, 3'd7, 1'b1, '{3'd0, 1'b0}},
        '{OP_SPARE0, 3'd7, 3'd7, 1'b1, '{3'd0, 1'b0}},
        '{OP_SPARE1, 3'd0, 3'd7, 1'b1, '{3'd0, 1'b0}},
        '{OP_SPARE2, 3'd7, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_CLEAR,  3'd7, 3'd7, 1'b1, '{3'd0, 1'b0}},
        '{OP_FIND,   3'd0, 3'd0, 1'b0, '{3'd0, 1'b0}},
        '{OP_FREE,   3'd0, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_FREE,   3'd3, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_FREE,   3'd7, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_FIND,   3'd0, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_SWAP,   3'd7, 3'd0, 1'b1, '{3'd0, 1'b0}},
        '{OP_REFERENCE, 3'd5, 3'd2, 1'b1, '{3'd0, 1'b0}},
        '{OP_FIND,   3'd7, 3'd7, 1'b0, '{3'd0, 1'b0}}
    };

    matrix_lru_replacement #(
        .FRAMES(N)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_frame_a      (i_frame_a),
        .i_frame_b      (i_frame_b),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_victim_frame (o_victim_frame),
        .o_victim_found (o_victim_found)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic apply_lru(input logic [OP_W-1:0] op, input logic [FRAME_W-1:0] fa,
                             input logic [FRAME_W-1:0] fb, output t_victim_word word);
        logic [N-1:0] tmp;
        logic         bit_a;
        logic         bit_b;
        logic [N-1:0] best;
        word = '0;
        best = '0;
        case (op)
            OP_REFERENCE: begin
                if (fa < N) begin
                    lru_rows[fa] = '1;
                    for (int r = 0; r < N; r++) lru_rows[r][N-1-fa] = 1'b0;
                    occ_marks[fa] = 1'b1;
                end
            end
            OP_FREE: begin
                if (fa < N) begin
                    lru_rows[fa] = '0;
                    occ_marks[fa] = 1'b0;
                end
            end
            OP_SWAP: begin
                if (fa < N && fb < N && fa != fb) begin
                    tmp = lru_rows[fa];
                    lru_rows[fa] = lru_rows[fb];
                    lru_rows[fb] = tmp;
                    for (int r = 0; r < N; r++) begin
                        bit_a = lru_rows[r][N-1-fa];
                        bit_b = lru_rows[r][N-1-fb];
                        lru_rows[r][N-1-fa] = bit_b;
                        lru_rows[r][N-1-fb] = bit_a;
                    end
                    bit_a = occ_marks[fa];
                    occ_marks[fa] = occ_marks[fb];
                    occ_marks[fb] = bit_a;
                end
            end
            OP_FIND: begin
                for (int r = 0; r < N; r++) begin
                    if (occ_marks[r] && (!word.found || lru_rows[r] < best)) begin
                        best = lru_rows[r];
                        word.frame = FRAME_W'(r);
                        word.found = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                for (int r = 0; r < N; r++) lru_rows[r] = '0;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_victim_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (victim_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: frame %0d found %0b", o_victim_frame,
                             o_victim_found);
                end
            end else begin
                want = victim_q.pop_front();
                if (o_victim_frame !== want.frame || o_victim_found !== want.found) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected frame %0d found %0b, %s %0d found %0b",
                                 want.frame, want.found, "got frame", o_victim_frame,
                                 o_victim_found);
                    end
                end
            end
        end
    end

    initial begin
        int len;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            len = pick_gap();
            if (len > 0) begin
                i_out_stall <= 1'b1;
                repeat (len) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        t_lru_cmd     cmd;
        t_victim_word got;
        int           gap;
        int           r;
        for (int f = 0; f < N; f++) lru_rows[f] = '0;
        occ_marks = '0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_opcode   <= '0;
        i_frame_a  <= '0;
        i_frame_b  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < PLAN_LEN + RANDOM_WORDS; i++) begin
            if (i < PLAN_LEN) begin
                cmd = plan[i];
            end else begin
                r = $urandom_range(0, 99);
                cmd = '0;
                cmd.fa = FRAME_W'($urandom_range(0, N - 1));
                cmd.fb = FRAME_W'($urandom_range(0, N - 1));
                if (r < 45) begin
                    cmd.op = OP_REFERENCE;
                end else if (r < 55) begin
                    cmd.op = OP_FREE;
                end else if (r < 70) begin
                    cmd.op = OP_SWAP;
                end else if (r < 97) begin
                    cmd.op = OP_FIND;
                end else if (r < 98) begin
                    cmd.op = OP_CLEAR;
                end else begin
                    cmd.op = OP_W'($urandom_range(OP_SPARE0, OP_SPARE2));
                end
                calm = ((i - PLAN_LEN) % 400) >= 340;
            end

            i_opcode   <= cmd.op;
            i_frame_a  <= cmd.fa;
            i_frame_b  <= cmd.fb;
            i_in_valid <= 1'b1;
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);

            apply_lru(cmd.op, cmd.fa, cmd.fb, got);
            victim_q.push_back(cmd.typed ? cmd.want : got);

            gap = pick_gap();
            if (i == PAUSE_AT && gap == 0) gap = 1;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                if (i == PAUSE_AT) begin
                    while (victim_q.size() != 0) @(posedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;
        calm = 1'b0;

        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (2 * N + 4) @(posedge i_clk);
        if (mismatches == 0 && victim_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
sv/mlru_pkg.sv
sv/mlru_ctrl.sv
sv/mlru_dp.sv
sv/matrix_lru_replacement.sv
dv/tb_top.sv
